FILE: rtl/hexld_pkg.sv
// Shared types, codes and character helpers for the hex text memory loader.
// Used by every module under rtl; depends on nothing else.
package hexld_pkg;

  localparam int ADDR_BITS_DEFAULT = 16;
  localparam int OCC_ROW_BITS = 5;
  localparam int SIZE_WIDTH = 17;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_DIGIT = 2'd0;
  localparam logic [1:0] ERR_ODD   = 2'd1;
  localparam logic [1:0] ERR_SIZE  = 2'd2;
  localparam logic [1:0] ERR_TWICE = 2'd3;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_AT      = 8'h40;
  localparam logic [7:0] CHAR_DEL     = 8'h7F;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [1:0]  error_code;
    logic [15:0] top_address;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] code;
    logic [7:0] data;
  } cand_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR && c != CHAR_NEWLINE);
  endfunction

endpackage

FILE: rtl/hexld_parse.sv
// Line parser: turns one character per request into a write, error or done candidate, or none.
// Holds load address and line state; depends on hexld_pkg.
module hexld_parse #(
  parameter int ADDR_BITS = hexld_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hexld_pkg::in_item_t    item,
  input  logic                   take,
  input  logic [ADDR_BITS:0]     size_limit,
  output hexld_pkg::cand_t       cand,
  output logic [ADDR_BITS-1:0]   cand_addr
);
  import hexld_pkg::*;

  localparam logic [2:0] PH_START     = 3'd0;
  localparam logic [2:0] PH_DATA      = 3'd1;
  localparam logic [2:0] PH_AT_SKIP   = 3'd2;
  localparam logic [2:0] PH_AT_DIGITS = 3'd3;
  localparam logic [2:0] PH_IGNORE    = 3'd4;

  logic [2:0]         phase, phase_next;
  logic [ADDR_BITS:0] load_address, load_address_next;
  logic [ADDR_BITS:0] accum, accum_next;
  logic [3:0]         high_nibble, high_nibble_next;
  logic               pending, pending_next;

  logic [7:0]           c;
  logic [4:0]           hv;
  logic                 data_mode;
  logic                 pend_eff;
  logic [ADDR_BITS+4:0] acc_shift;

  assign c = item.char_code;
  assign hv = hex_value(c);
  assign pend_eff = (phase == PH_START) ? 1'b0 : pending;
  assign acc_shift = {accum, hv[3:0]};
  assign cand_addr = load_address[ADDR_BITS-1:0];

  always_comb begin
    phase_next = phase;
    load_address_next = load_address;
    accum_next = accum;
    high_nibble_next = high_nibble;
    pending_next = pending;
    cand = '{op: OP_NONE, code: ERR_DIGIT, data: 8'd0};
    data_mode = 1'b0;
    if (item.action) begin
      if (phase == PH_DATA && pending) begin
        cand.op = OP_ERROR;
        cand.code = ERR_ODD;
      end else begin
        phase_next = PH_START;
        pending_next = 1'b0;
        cand.op = OP_DONE;
      end
    end else if (c == CHAR_NEWLINE && phase != PH_DATA) begin
      phase_next = PH_START;
    end else begin
      unique case (phase)
        PH_START: begin
          if (c == CHAR_AT) begin
            phase_next = PH_AT_SKIP;
            accum_next = '0;
          end else begin
            phase_next = PH_DATA;
            data_mode = 1'b1;
          end
        end
        PH_DATA: begin
          data_mode = 1'b1;
        end
        PH_AT_SKIP, PH_AT_DIGITS: begin
          if (!hv[4]) begin
            if (!(phase == PH_AT_SKIP && is_blank(c))) begin
              phase_next = PH_IGNORE;
            end
          end else begin
            phase_next = PH_AT_DIGITS;
            accum_next = (|accum[ADDR_BITS:ADDR_BITS-3]) ? '1 : acc_shift[ADDR_BITS:0];
            load_address_next = accum_next;
          end
        end
        default: begin
        end
      endcase
    end

    if (data_mode) begin
      pending_next = pend_eff;
      if (c == CHAR_NEWLINE) begin
        if (pend_eff) begin
          cand.op = OP_ERROR;
          cand.code = ERR_ODD;
        end else begin
          phase_next = PH_START;
        end
      end else if (c <= CHAR_SPACE || c >= CHAR_DEL) begin
        pending_next = pend_eff;
      end else if (!hv[4]) begin
        cand.op = OP_ERROR;
        cand.code = ERR_DIGIT;
      end else if (!pend_eff) begin
        high_nibble_next = hv[3:0];
        pending_next = 1'b1;
      end else begin
        pending_next = 1'b0;
        if (load_address >= size_limit) begin
          cand.op = OP_ERROR;
          cand.code = ERR_SIZE;
        end else begin
          cand.op = OP_WRITE;
          cand.data = {high_nibble, hv[3:0]};
          load_address_next = load_address + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      load_address <= '0;
      accum <= '0;
      high_nibble <= '0;
      pending <= 1'b0;
    end else if (take) begin
      phase <= phase_next;
      load_address <= load_address_next;
      accum <= accum_next;
      high_nibble <= high_nibble_next;
      pending <= pending_next;
    end
  end

endmodule

FILE: rtl/hexld_occ.sv
// Occupancy bitmap memory with clearing pass, read-modify-write commit stage and
// forwarding, plus the highest-address and sticky-error state. Depends on hexld_pkg.
module hexld_occ #(
  parameter int ADDR_BITS = hexld_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic                   load_valid,
  output logic                   load_ready,
  input  hexld_pkg::cand_t       cand,
  input  logic [ADDR_BITS-1:0]   cand_addr,
  output logic                   res_fire,
  output hexld_pkg::out_item_t   res
);
  import hexld_pkg::*;

  localparam int ROW_IDX = ADDR_BITS - OCC_ROW_BITS;
  localparam int ROWS = 1 << ROW_IDX;
  localparam int ROW_W = 1 << OCC_ROW_BITS;

  logic [ROW_W-1:0] occ_mem [ROWS];

  logic                 busy;
  logic [ROW_IDX-1:0]   clr_idx;
  logic                 p_valid;
  cand_t                p_cand;
  logic [ADDR_BITS-1:0] p_addr;
  logic [ROW_W-1:0]     rd_row;
  logic                 fwd_hit;
  logic [ROW_W-1:0]     fwd_row;
  logic [ADDR_BITS-1:0] highest;
  logic                 failed;

  logic                  load;
  logic                  commit_fire;
  logic                  res_valid;
  logic                  wr_commit;
  logic [ROW_W-1:0]      row_eff;
  logic                  bit_set;
  logic                  mem_we;
  logic [ROW_IDX-1:0]    mem_wa;
  logic [ROW_W-1:0]      mem_wd;
  logic [ROW_IDX-1:0]    p_row;
  logic [ROW_IDX-1:0]    load_row;
  logic [ADDR_BITS+15:0] p_addr_ext;
  logic [ADDR_BITS+15:0] highest_ext;

  assign load_ready = !busy && (!p_valid || go);
  assign load = load_valid && load_ready;
  assign commit_fire = p_valid && go;
  assign p_row = p_addr[ADDR_BITS-1:OCC_ROW_BITS];
  assign load_row = cand_addr[ADDR_BITS-1:OCC_ROW_BITS];
  assign row_eff = fwd_hit ? fwd_row : rd_row;
  assign bit_set = row_eff[p_addr[OCC_ROW_BITS-1:0]];
  assign p_addr_ext = {16'd0, p_addr};
  assign highest_ext = {16'd0, highest};

  always_comb begin
    res_valid = 1'b0;
    wr_commit = 1'b0;
    res.kind = KIND_WRITE;
    res.address = p_addr_ext[15:0];
    res.data = p_cand.data;
    res.error_code = ERR_DIGIT;
    res.top_address = highest_ext[15:0];
    if (p_valid && !failed) begin
      unique case (p_cand.op)
        OP_NONE: begin
        end
        OP_WRITE: begin
          res_valid = 1'b1;
          if (bit_set) begin
            res.kind = KIND_ERROR;
            res.error_code = ERR_TWICE;
            res.data = 8'd0;
          end else begin
            wr_commit = commit_fire;
            if (p_addr > highest) begin
              res.top_address = p_addr_ext[15:0];
            end
          end
        end
        OP_ERROR: begin
          res_valid = 1'b1;
          res.kind = KIND_ERROR;
          res.error_code = p_cand.code;
        end
        OP_DONE: begin
          res_valid = 1'b1;
          res.kind = KIND_DONE;
          res.address = 16'd0;
        end
        default: begin
        end
      endcase
    end
  end

  assign res_fire = commit_fire && res_valid;
  assign mem_we = busy || wr_commit;
  assign mem_wa = busy ? clr_idx : p_row;
  assign mem_wd = busy ? '0 : (row_eff | (ROW_W'(1) << p_addr[OCC_ROW_BITS-1:0]));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_wa] <= mem_wd;
    end
    if (load) begin
      rd_row <= occ_mem[load_row];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_cand <= cand;
      p_addr <= cand_addr;
      fwd_row <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      clr_idx <= '0;
      p_valid <= 1'b0;
      fwd_hit <= 1'b0;
      highest <= '0;
      failed <= 1'b0;
    end else begin
      if (busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (&clr_idx) begin
          busy <= 1'b0;
        end
      end
      if (load) begin
        p_valid <= 1'b1;
        fwd_hit <= wr_commit && (p_row == load_row);
      end else if (commit_fire) begin
        p_valid <= 1'b0;
        fwd_hit <= 1'b0;
      end
      if (res_fire && res.kind == KIND_ERROR) begin
        failed <= 1'b1;
      end
      if (wr_commit && p_addr > highest) begin
        highest <= p_addr;
      end
    end
  end

  a_no_load_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !load)
    else $error("request accepted during the clearing pass");

  a_commit_not_during_clear: assert property (@(posedge clk) disable iff (rst)
    wr_commit |-> !busy)
    else $error("commit write collides with the clearing pass");

  a_forward_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> p_valid)
    else $error("forwarded row without an item in the commit stage");

  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    failed |=> failed)
    else $error("error state cleared without reset");

endmodule

FILE: rtl/hex_text_memory_loader.sv
// Top level of the hex text memory loader: config register, parser, occupancy
// commit stage and output register. Depends on hexld_pkg, hexld_parse, hexld_occ.
//
// The loader takes one text character request per cycle unless the clearing pass or
// output back-pressure holds it, and presents each result in the output register as
// the character leaves the commit stage; that register lets the next character enter
// while a result waits. The occupancy bitmap memory sets the rate: it is read on
// accept and written back on leaving the commit stage, with forwarding when consecutive
// writes fall in the same row. After reset the bitmap is cleared one 32-bit row per
// cycle over 2^(ADDR_BITS-5) rows (2048 at the default of 16 address bits), and in_ready
// stays low meanwhile; the size limit may be written at any time the block is idle.
module hex_text_memory_loader #(
  parameter int ADDR_BITS = hexld_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  hexld_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output hexld_pkg::out_item_t             out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hexld_pkg::SIZE_WIDTH-1:0] cfg_data
);
  import hexld_pkg::*;

  logic [ADDR_BITS:0]              size_limit;
  logic [ADDR_BITS+SIZE_WIDTH-1:0] cfg_ext;
  logic                            go;
  logic                            take;
  cand_t                           cand;
  logic [ADDR_BITS-1:0]            cand_addr;
  logic                            res_fire;
  out_item_t                       res;

  assign cfg_ready = 1'b1;
  assign cfg_ext = {{ADDR_BITS{1'b0}}, cfg_data};
  assign go = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= (ADDR_BITS+1)'(1) << ADDR_BITS;
    end else if (cfg_valid && cfg_ready) begin
      size_limit <= cfg_ext[ADDR_BITS:0];
    end
  end

  hexld_parse #(.ADDR_BITS(ADDR_BITS)) u_parse (
    .clk        (clk),
    .rst        (rst),
    .item       (in_item),
    .take       (take),
    .size_limit (size_limit),
    .cand       (cand),
    .cand_addr  (cand_addr)
  );

  hexld_occ #(.ADDR_BITS(ADDR_BITS)) u_occ (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .load_valid (in_valid),
    .load_ready (in_ready),
    .cand       (cand),
    .cand_addr  (cand_addr),
    .res_fire   (res_fire),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Testbench for hex_text_memory_loader. It streams memory-image text and ends of input,
// predicts every byte write, completion and error, and checks each result as it leaves.
// Depends on hexld_pkg and the RTL top level; it reads no files.
module testbench;
  import hexld_pkg::*;

  typedef enum logic [2:0] {
    LINE_START, LINE_DATA, LINE_AT_SKIP, LINE_AT_DIGITS, LINE_IGNORE
  } line_state_t;

  localparam int MEM_BYTES = 1 << ADDR_BITS_DEFAULT;
  localparam logic [16:0] FULL_SIZE = 17'h10000;
  localparam logic [16:0] ACC_MAX = 17'h1FFFF;
  localparam logic [1:0] NO_ERROR = 2'd0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SIZE_WIDTH-1:0] cfg_data = '0;

  bit mem_used [MEM_BYTES];
  logic [16:0] ram_limit = FULL_SIZE;
  logic [16:0] load_addr = '0;
  logic [16:0] addr_accum = '0;
  logic [15:0] top_addr = '0;
  line_state_t line_state = LINE_START;
  logic [3:0] upper_nibble = '0;
  bit nibble_waiting = 1'b0;
  bit load_failed = 1'b0;
  out_item_t expected_loads [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent_chars = 0;
  int write_count = 0;
  int done_count = 0;
  int error_count = 0;
  int mismatch_count = 0;

  hex_text_memory_loader u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void expect_result(logic [1:0] kind, logic [15:0] addr,
                                        logic [7:0] value, logic [1:0] code);
    out_item_t r;
    r.kind = kind;
    r.address = addr;
    r.data = value;
    r.error_code = code;
    r.top_address = top_addr;
    expected_loads.insert(expected_loads.size(), r);
  endfunction

  function automatic void raise_error(logic [1:0] code);
    load_failed = 1'b1;
    expect_result(KIND_ERROR, load_addr[15:0], 8'h00, code);
  endfunction

  function automatic void take_data_char(logic [7:0] c);
    int v;
    logic [15:0] a;
    v = hex_of(c);
    a = load_addr[15:0];
    if (c == CHAR_NEWLINE) begin
      if (nibble_waiting) begin
        raise_error(ERR_ODD);
      end else begin
        line_state = LINE_START;
      end
    end else if (c > CHAR_SPACE && c < CHAR_DEL) begin
      if (v < 0) begin
        raise_error(ERR_DIGIT);
      end else if (!nibble_waiting) begin
        upper_nibble = v[3:0];
        nibble_waiting = 1'b1;
      end else begin
        nibble_waiting = 1'b0;
        if (load_addr >= ram_limit) begin
          raise_error(ERR_SIZE);
        end else if (mem_used[a]) begin
          raise_error(ERR_TWICE);
        end else begin
          mem_used[a] = 1'b1;
          if (a > top_addr) top_addr = a;
          expect_result(KIND_WRITE, a, {upper_nibble, v[3:0]}, NO_ERROR);
          load_addr = load_addr + 17'd1;
        end
      end
    end
  endfunction

  function automatic void predict_char(logic act, logic [7:0] c);
    int v;
    logic [20:0] wide;
    v = hex_of(c);
    if (load_failed) return;
    if (act) begin
      if (line_state == LINE_DATA && nibble_waiting) begin
        raise_error(ERR_ODD);
      end else begin
        line_state = LINE_START;
        nibble_waiting = 1'b0;
        expect_result(KIND_DONE, 16'h0000, 8'h00, NO_ERROR);
      end
      return;
    end
    if (c == CHAR_NEWLINE && line_state != LINE_DATA) begin
      line_state = LINE_START;
      return;
    end
    case (line_state)
      LINE_START: begin
        if (c == CHAR_AT) begin
          line_state = LINE_AT_SKIP;
          addr_accum = '0;
        end else begin
          line_state = LINE_DATA;
          nibble_waiting = 1'b0;
          take_data_char(c);
        end
      end
      LINE_DATA: take_data_char(c);
      LINE_AT_SKIP, LINE_AT_DIGITS: begin
        if (v < 0) begin
          if (!(line_state == LINE_AT_SKIP && (c == CHAR_SPACE || c == CHAR_TAB ||
                c == 8'h0B || c == 8'h0C || c == CHAR_CR))) begin
            line_state = LINE_IGNORE;
          end
        end else begin
          line_state = LINE_AT_DIGITS;
          wide = {addr_accum, v[3:0]};
          addr_accum = (wide > 21'(ACC_MAX)) ? ACC_MAX : wide[16:0];
          load_addr = addr_accum;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_loads.size() == 0) begin
        $error("kind: expected no result, got 0x%0h (address 0x%0h)",
               out_item.kind, out_item.address);
        mismatch_count++;
      end else begin
        want = expected_loads.pop_front();
        compare_field("kind", 16'(want.kind), 16'(out_item.kind));
        compare_field("address", want.address, out_item.address);
        compare_field("data", 16'(want.data), 16'(out_item.data));
        compare_field("error_code", 16'(want.error_code), 16'(out_item.error_code));
        compare_field("top_address", want.top_address, out_item.top_address);
      end
      case (out_item.kind)
        KIND_WRITE: write_count++;
        KIND_DONE: done_count++;
        default: error_count++;
      endcase
    end
  end

  task automatic send_char(input logic act, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{action: act, char_code: c};
    do @(posedge clk); while (!in_ready);
    predict_char(act, c);
    sent_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(1'b0, s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_loads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size_limit(input logic [16:0] size);
    cfg_valid <= 1'b1;
    cfg_data <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ram_limit = size;
  endtask

  function automatic logic [7:0] digit_char(logic [3:0] n);
    string digits;
    digits = $urandom_range(1) ? "0123456789ABCDEF" : "0123456789abcdef";
    return digits[n];
  endfunction

  // Characters that a data line skips: control codes but newline, space, DEL and the upper half.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    if ($urandom_range(1)) begin
      do c = 8'($urandom_range(32)); while (c == CHAR_NEWLINE);
    end else begin
      c = 8'($urandom_range(255, 127));
    end
    return c;
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CHAR_NEWLINE);
    return c;
  endfunction

  function automatic int free_run(logic [16:0] start, int limit);
    int n;
    n = 0;
    while (n < limit && start + n < ram_limit && !mem_used[16'(start + n)]) n++;
    return n;
  endfunction

  task automatic send_address(input logic [16:0] addr);
    string blanks;
    string tail;
    int ndig;
    blanks = " \t\r\013\014";
    tail = " \r+-xz#;";
    send_char(1'b0, CHAR_AT);
    repeat ($urandom_range(2)) send_char(1'b0, blanks[$urandom_range(4)]);
    ndig = 1;
    while (ndig < 5 && (addr >> (4 * ndig)) != 0) ndig++;
    ndig += $urandom_range(2);
    for (int i = ndig - 1; i >= 0; i--) send_char(1'b0, digit_char(4'(addr >> (4 * i))));
    if ($urandom_range(3) == 0) begin
      send_char(1'b0, tail[$urandom_range(tail.len() - 1)]);
      repeat ($urandom_range(4)) send_char(1'b0, any_but_newline());
    end
    send_char(1'b0, CHAR_NEWLINE);
  endtask

  task automatic send_bytes(input int count, input bit close_line);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if ($urandom_range(3) == 0) send_char(1'b0, filler_char());
      send_char(1'b0, digit_char(b[7:4]));
      if ($urandom_range(7) == 0) send_char(1'b0, filler_char());
      send_char(1'b0, digit_char(b[3:0]));
    end
    if (close_line) send_char(1'b0, CHAR_NEWLINE);
  endtask

  task automatic send_block();
    logic [16:0] start;
    int n;
    int part;
    case ($urandom_range(11))
      0: begin
        send_char(1'b0, CHAR_AT);
        repeat ($urandom_range(6, 1)) send_char(1'b0, any_but_newline());
        send_char(1'b0, CHAR_NEWLINE);
      end
      1: begin
        repeat ($urandom_range(4, 1)) send_char(1'b0, filler_char());
        send_char(1'b0, CHAR_NEWLINE);
      end
      2: send_char(1'b1, 8'($urandom));
      3: begin
        send_char(1'b0, CHAR_AT);
        send_char(1'b0, digit_char(4'($urandom_range(15, 1))));
        repeat ($urandom_range(7, 5)) send_char(1'b0, digit_char(4'($urandom)));
        send_char(1'b0, CHAR_NEWLINE);
      end
      default: begin
        start = 17'($urandom_range(int'(ram_limit) - 1));
        n = free_run(start, $urandom_range(12, 1));
        send_address(start);
        while (n > 0) begin
          part = $urandom_range(n, 1);
          n -= part;
          if (n == 0 && $urandom_range(4) == 0) begin
            send_bytes(part, 1'b0);
            send_char(1'b1, 8'($urandom));
          end else begin
            send_bytes(part, 1'b1);
          end
        end
      end
    endcase
  endtask

  task automatic test_directed();
    send_idle_pct = 12;
    recv_stall_pct = 68;
    write_size_limit(17'd1);
    send_text("A5\n");
    send_char(1'b1, 8'hFF);
    drain();
    write_size_limit(FULL_SIZE);
    send_text("@ \tFfFf+z\n");
    send_text("\177f0");
    send_char(1'b1, 8'h00);
    send_text("@\n");
    send_text("@\013\0140x3\n");
  endtask

  task automatic test_random_text(input int idle_pct, input int stall_pct,
                                  input logic [16:0] size, input int count);
    int stop_at;
    drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_size_limit(size);
    stop_at = sent_chars + count;
    while (sent_chars < stop_at) send_block();
  endtask

  task automatic test_sticky_error();
    logic [16:0] spot;
    logic [7:0] bad;
    drain();
    do spot = 17'($urandom_range(int'(ram_limit) - 1)); while (mem_used[spot[15:0]]);
    case ($urandom_range(4))
      0: begin
        do bad = 8'($urandom_range(126, 33)); while (hex_of(bad) >= 0);
        send_address(spot);
        send_text("1");
        send_char(1'b0, bad);
      end
      1: begin
        send_address(spot);
        send_text("7\n");
      end
      2: begin
        send_address(spot);
        send_text("abc");
        send_char(1'b1, 8'($urandom));
      end
      3: begin
        if ($urandom_range(1)) begin
          send_text("@FFFFFF\n");
        end else begin
          send_address(ram_limit);
        end
        send_text("00\n");
      end
      default: begin
        send_address({1'b0, top_addr});
        send_text("5a\n");
      end
    endcase
    repeat (4) send_block();
    send_char(1'b1, 8'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_text(12, 68, 17'($urandom_range(65535, 2)), 330);
    test_random_text(68, 12, 17'($urandom_range(300, 1)), 330);
    test_random_text(0, 0, FULL_SIZE, 330);
    test_sticky_error();
    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d characters under four RAM sizes and three handshake pacings.",
             sent_chars);
    $display("Checked %0d byte writes, %0d end-of-input reports and %0d error.",
             write_count, done_count, error_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $error("Run did not finish in time; %0d results still expected.", expected_loads.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
